// ===== design/msi_pkg.sv =====
// Shared types, constants and saturation helpers for the mass-spring particle core.
// No dependencies; every other file uses this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package msi_pkg;

  localparam int CRD_W  = 32;
  localparam int ACC_W  = 48;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 32;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_LINK = 2'd1,
    KIND_STEP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_STIFFNESS = 2'd0,
    REG_FRICTION  = 2'd1,
    REG_INV_MASS  = 2'd2
  } reg_index_t;

  typedef enum logic {
    RT_SQRT = 1'b0,
    RT_DIV  = 1'b1
  } root_mode_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CRD_W-1:0]  coord_x;
    logic signed [CRD_W-1:0]  coord_y;
    logic signed [CRD_W-1:0]  speed_x;
    logic signed [CRD_W-1:0]  speed_y;
    logic [30:0]              rest_length;
    logic [23:0]              elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] new_pos_x;
    logic signed [CRD_W-1:0] new_pos_y;
    logic signed [CRD_W-1:0] new_vel_x;
    logic signed [CRD_W-1:0] new_vel_y;
  } out_item_t;

  typedef struct packed {
    logic                    go;
    logic signed [ACC_W-1:0] a;
    logic [31:0]             b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] fx;
    logic [63:0]             prod;
  } mul_rsp_t;

  typedef struct packed {
    logic       go;
    root_mode_t mode;
    logic [63:0] src;
    logic [32:0] divisor;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] res;
  } root_rsp_t;

  localparam logic signed [49:0] ACC_MAX50 = 50'sd140737488355327;
  localparam logic signed [49:0] ACC_MIN50 = -50'sd140737488355328;
  localparam logic signed [49:0] CRD_MAX50 = 50'sd2147483647;
  localparam logic signed [49:0] CRD_MIN50 = -50'sd2147483648;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [49:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ACC_MAX50) r = ACC_MAX50[ACC_W-1:0];
    else if (v < ACC_MIN50) r = ACC_MIN50[ACC_W-1:0];
    else r = v[ACC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [49:0] v);
    logic signed [CRD_W-1:0] r;
    if (v > CRD_MAX50) r = CRD_MAX50[CRD_W-1:0];
    else if (v < CRD_MIN50) r = CRD_MIN50[CRD_W-1:0];
    else r = v[CRD_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/msi_in_if.sv =====
// Input channel: valid/ready handshake carrying one input word.
// Depends on msi_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface msi_in_if;
  logic             valid;
  logic             ready;
  msi_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/msi_out_if.sv =====
// Output channel: valid/ready handshake carrying one result word.
// Depends on msi_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface msi_out_if;
  logic              valid;
  logic              ready;
  msi_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/mass_spring_particle_integrator_core.sv =====
// Top level: particle state, configuration registers and the sequencer that drives
// the shared multiplier (msi_mul) and root/divide unit (msi_root). Uses msi_pkg.
//
//   channel   dir  handshake      word
//   items     in   valid/ready    kind, coords, speeds, rest_length, elapsed
//   results   out  valid/ready    new_pos_x/y, new_vel_x/y
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// Set and unknown words are taken without leaving the idle state. A link word runs two
// squares, a 32-step root, two 48-step divides and three products.
// A step word runs ten products on the shared multiplier.
// Synchronous reset clears state to zero and registers to their defaults.
// A finished result waits in the output register; a new word is taken meanwhile,
// and the next step result holds until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module mass_spring_particle_integrator_core (
  input  logic             clk,
  input  logic             rst,
  msi_in_if.sink           items,
  msi_out_if.source        results,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_KMUL, ST_DIV, ST_FMUL,
    ST_ACCEL, ST_DV, ST_HALF, ST_VE, ST_NV, ST_OUT
  } state_t;

  state_t state;

  logic [31:0] stiffness;
  logic [16:0] friction;
  logic [31:0] inv_mass;

  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic signed [47:0] force_acc_x, force_acc_y;

  logic signed [32:0] dx, dy;
  logic [30:0] rest;
  logic [23:0] elapsed;
  logic [63:0] nsum;
  logic [32:0] span;
  logic signed [47:0] k;
  logic [31:0] u;
  logic        axis;
  logic signed [47:0] accel, dv, half, disp;
  logic        mul_go, root_go;

  msi_pkg::mul_req_t  mul_req;
  msi_pkg::mul_rsp_t  mul_rsp;
  msi_pkg::root_req_t root_req;
  msi_pkg::root_rsp_t root_rsp;

  logic [31:0] ax, ay;
  logic signed [32:0] d_sel;
  logic signed [31:0] p_sel, v_sel;
  logic signed [47:0] f_sel;
  logic signed [33:0] stretch;
  logic signed [47:0] part;
  logic signed [47:0] half_c;
  logic signed [48:0] h_sum;

  msi_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  msi_root u_root (.clk(clk), .rst(rst), .req(root_req), .rsp(root_rsp));

  assign ax      = 32'(dx[32] ? -dx : dx);
  assign ay      = 32'(dy[32] ? -dy : dy);
  assign d_sel   = axis ? dy : dx;
  assign p_sel   = axis ? pos_y : pos_x;
  assign v_sel   = axis ? vel_y : vel_x;
  assign f_sel   = axis ? force_acc_y : force_acc_x;
  assign stretch = $signed({3'b0, rest}) - $signed({1'b0, span});
  assign part    = d_sel[32] ? msi_pkg::sat_acc(-50'(mul_rsp.fx)) : mul_rsp.fx;
  assign h_sum   = 49'(mul_rsp.fx) + $signed({48'b0, mul_rsp.fx[47]});
  assign half_c  = 48'(h_sum >>> 1);

  always_comb begin
    mul_req.go = mul_go;
    mul_req.a  = '0;
    mul_req.b  = '0;
    unique case (state)
      ST_SQX:   begin mul_req.a = 48'(ax); mul_req.b = ax; end
      ST_SQY:   begin mul_req.a = 48'(ay); mul_req.b = ay; end
      ST_KMUL:  begin mul_req.a = 48'(stretch); mul_req.b = stiffness; end
      ST_FMUL:  begin mul_req.a = k; mul_req.b = u; end
      ST_ACCEL: begin mul_req.a = f_sel; mul_req.b = inv_mass; end
      ST_DV:    begin mul_req.a = accel; mul_req.b = 32'(elapsed); end
      ST_HALF:  begin mul_req.a = dv; mul_req.b = 32'(elapsed); end
      ST_VE:    begin mul_req.a = 48'(v_sel); mul_req.b = 32'(elapsed); end
      ST_NV: begin
        mul_req.a = msi_pkg::sat_acc(50'(v_sel) + 50'(dv));
        mul_req.b = 32'(friction);
      end
      default: ;
    endcase
  end

  always_comb begin
    root_req.go      = root_go;
    root_req.divisor = span;
    if (state == ST_ROOT) begin
      root_req.mode = msi_pkg::RT_SQRT;
      root_req.src  = nsum;
    end else begin
      root_req.mode = msi_pkg::RT_DIV;
      root_req.src  = {axis ? ay : ax, 32'b0};
    end
  end

  assign items.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= 32'd65536;
      friction  <= 17'd65536;
      inv_mass  <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msi_pkg::REG_STIFFNESS: stiffness <= cfg_data;
        msi_pkg::REG_FRICTION:  friction  <= cfg_data[16:0];
        msi_pkg::REG_INV_MASS:  inv_mass  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mul_go        <= 1'b0;
      root_go       <= 1'b0;
      results.valid <= 1'b0;
      pos_x <= '0; pos_y <= '0; vel_x <= '0; vel_y <= '0;
      force_acc_x <= '0; force_acc_y <= '0;
    end else begin
      mul_go  <= 1'b0;
      root_go <= 1'b0;
      if (results.valid && results.ready && state != ST_OUT) results.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (items.valid) begin
            rest    <= items.data.rest_length;
            elapsed <= items.data.elapsed;
            axis    <= 1'b0;
            dx <= 33'(pos_x) - 33'(items.data.coord_x);
            dy <= 33'(pos_y) - 33'(items.data.coord_y);
            unique case (items.data.kind)
              msi_pkg::KIND_SET: begin
                pos_x <= items.data.coord_x;
                pos_y <= items.data.coord_y;
                vel_x <= items.data.speed_x;
                vel_y <= items.data.speed_y;
                force_acc_x <= '0;
                force_acc_y <= '0;
              end
              msi_pkg::KIND_LINK: begin
                state  <= ST_SQX;
                mul_go <= 1'b1;
              end
              msi_pkg::KIND_STEP: begin
                state  <= ST_ACCEL;
                mul_go <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_SQX: if (mul_rsp.done) begin
          nsum   <= {2'b0, mul_rsp.prod[63:2]};
          state  <= ST_SQY;
          mul_go <= 1'b1;
        end
        ST_SQY: if (mul_rsp.done) begin
          nsum    <= nsum + {2'b0, mul_rsp.prod[63:2]};
          state   <= ST_ROOT;
          root_go <= 1'b1;
        end
        ST_ROOT: if (root_rsp.done) begin
          span <= {root_rsp.res[31:0], 1'b0};
          if (root_rsp.res[31:0] == 32'd0) begin
            state <= ST_IDLE;
          end else begin
            state  <= ST_KMUL;
            mul_go <= 1'b1;
          end
        end
        ST_KMUL: if (mul_rsp.done) begin
          k       <= mul_rsp.fx;
          state   <= ST_DIV;
          root_go <= 1'b1;
        end
        ST_DIV: if (root_rsp.done) begin
          u      <= root_rsp.res[31:0];
          state  <= ST_FMUL;
          mul_go <= 1'b1;
        end
        ST_FMUL: if (mul_rsp.done) begin
          if (axis) begin
            force_acc_y <= msi_pkg::sat_acc(50'(force_acc_y) + 50'(part));
            state       <= ST_IDLE;
          end else begin
            force_acc_x <= msi_pkg::sat_acc(50'(force_acc_x) + 50'(part));
            axis        <= 1'b1;
            state       <= ST_DIV;
            root_go     <= 1'b1;
          end
        end
        ST_ACCEL: if (mul_rsp.done) begin
          accel  <= mul_rsp.fx;
          state  <= ST_DV;
          mul_go <= 1'b1;
        end
        ST_DV: if (mul_rsp.done) begin
          dv     <= mul_rsp.fx;
          state  <= ST_HALF;
          mul_go <= 1'b1;
        end
        ST_HALF: if (mul_rsp.done) begin
          half   <= half_c;
          state  <= ST_VE;
          mul_go <= 1'b1;
        end
        ST_VE: if (mul_rsp.done) begin
          disp   <= msi_pkg::sat_acc(50'(half) + 50'(mul_rsp.fx));
          state  <= ST_NV;
          mul_go <= 1'b1;
        end
        ST_NV: if (mul_rsp.done) begin
          if (axis) begin
            pos_y <= msi_pkg::sat_crd(50'(pos_y) + 50'(disp));
            vel_y <= msi_pkg::sat_crd(50'(mul_rsp.fx));
            force_acc_x <= '0;
            force_acc_y <= '0;
            state <= ST_OUT;
          end else begin
            pos_x  <= msi_pkg::sat_crd(50'(pos_x) + 50'(disp));
            vel_x  <= msi_pkg::sat_crd(50'(mul_rsp.fx));
            axis   <= 1'b1;
            state  <= ST_ACCEL;
            mul_go <= 1'b1;
          end
        end
        ST_OUT: if (!results.valid || results.ready) begin
          results.data.new_pos_x <= pos_x;
          results.data.new_pos_y <= pos_y;
          results.data.new_vel_x <= vel_x;
          results.data.new_vel_y <= vel_y;
          results.valid <= 1'b1;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |-> (state == ST_IDLE))
    else $error("word accepted while busy");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    mul_go |-> !root_go)
    else $error("both shared units started together");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside output state");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> (force_acc_x == '0 && force_acc_y == '0))
    else $error("force accumulator not cleared after step");

endmodule
`default_nettype wire

// ===== design/msi_mul.sv =====
// Iterative sign-magnitude multiplier, 48 x 32 bits as three 16 x 32 passes.
// Gives the low 64 bits of the magnitude product and the saturated fixed-point product. Uses msi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msi_mul (
  input  logic              clk,
  input  logic              rst,
  input  msi_pkg::mul_req_t req,
  output msi_pkg::mul_rsp_t rsp
);

  localparam int LAST = 2;

  logic        neg;
  logic [47:0] mag;
  logic [31:0] bb;
  logic [79:0] prod;
  logic [1:0]  cnt;
  logic        busy;
  logic        fin;
  logic        done;
  logic signed [47:0] fx;
  logic [63:0] prod_out;
  logic [63:0] p;
  logic signed [47:0] fx_c;

  assign p = prod[79:16];

  always_comb begin
    if (neg) begin
      if (p > 64'h0000_8000_0000_0000) fx_c = 48'sh8000_0000_0000;
      else fx_c = 48'(-p);
    end else begin
      if (p > 64'h0000_7FFF_FFFF_FFFF) fx_c = 48'sh7FFF_FFFF_FFFF;
      else fx_c = p[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        neg  <= req.a[47];
        mag  <= req.a[47] ? 48'(~req.a + 48'sd1) : req.a;
        bb   <= req.b;
        prod <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= {prod[63:0], 16'b0} + 80'(mag[47:32] * bb);
        mag  <= {mag[31:0], 16'b0};
        cnt  <= cnt + 2'd1;
        if (cnt == 2'(LAST)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        done     <= 1'b1;
        fx       <= fx_c;
        prod_out <= prod[63:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.fx   = fx;
  assign rsp.prod = prod_out;

endmodule
`default_nettype wire

// ===== design/msi_root.sv =====
// Shared shift-and-subtract unit: integer square root (two radicand bits a cycle)
// or restoring division (one bit a cycle). Uses msi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msi_root (
  input  logic               clk,
  input  logic               rst,
  input  msi_pkg::root_req_t req,
  output msi_pkg::root_rsp_t rsp
);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 48;

  msi_pkg::root_mode_t mode;
  logic [63:0] src;
  logic [34:0] rem;
  logic [47:0] res;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [5:0]  last;

  always_comb begin
    if (mode == msi_pkg::RT_SQRT) begin
      rem_sh = {rem[33:0], src[63:62]};
      trial  = {2'b0, res[31:0], 2'b01};
      last   = 6'(SQRT_STEPS - 1);
    end else begin
      rem_sh = {rem[34:0], src[63]};
      trial  = {3'b0, dvs};
      last   = 6'(DIV_STEPS - 1);
    end
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        mode <= req.mode;
        src  <= req.src;
        dvs  <= req.divisor;
        rem  <= '0;
        res  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= 35'(ge ? rem_sh - trial : rem_sh);
        res <= {res[46:0], ge};
        src <= (mode == msi_pkg::RT_SQRT) ? {src[61:0], 2'b0} : {src[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule
`default_nettype wire
